// ----- rtl/fpap_pkg.sv -----
package fpap_pkg;

    // Default geometry of the per-channel state.
    localparam int CHANNELS_DEF = 16;
    localparam int STAGES_DEF   = 4;

    // Field widths.
    localparam int SAMPLE_W     = 24;
    localparam int GAIN_W       = 17;
    localparam int CHAN_FIELD_W = 4;
    localparam int CFG_IDX_W    = 2;

    // Shared multiplier operand and product widths.
    localparam int MA_W   = 25;
    localparam int MB_W   = 19;
    localparam int PROD_W = 44;

    // Unity gain in Q1.16.
    localparam logic [GAIN_W-1:0] Q16_ONE = 17'd65536;

    // Coefficient arithmetic: the product cv*depth is biased by half of the
    // divisor 10*2^19, shifted down by 20 and then divided by 5.
    localparam logic signed [PROD_W-1:0] CV_BIAS = 44'sd2621440;
    localparam logic signed [23:0]       M_LO    = -24'sd163840;
    localparam logic signed [23:0]       M_HI    = 24'sd163844;
    localparam logic signed [23:0]       U_OFS   = 24'sd163840;
    // floor(2^20 / 5), used for the reciprocal divide by five.
    localparam logic signed [MB_W-1:0]   RECIP_5 = 19'sd209715;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FEEDBACK = 2'd0,
        CFG_MIX      = 2'd1,
        CFG_DEPTH    = 2'd2
    } t_cfg_index;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_CV,
        S_FB,
        S_REC,
        S_COEF,
        S_MUL,
        S_ACC,
        S_MIXM,
        S_DONE
    } t_state;

    // Round a Q16-scaled product to nearest, halves toward +infinity.
    function automatic logic signed [27:0] round_q16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + 44'sd32768;
        return t[PROD_W-1:16];
    endfunction

    // Saturate to the signed 24-bit sample range.
    function automatic logic signed [23:0] sat24(input logic signed [29:0] v);
        if (v > 30'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (v < -30'sd8388608) begin
            return 24'sh800000;
        end else begin
            return v[23:0];
        end
    endfunction

    // Limit a gain register to 1.0.
    function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] v);
        return (v > Q16_ONE) ? Q16_ONE : v;
    endfunction

endpackage

// ----- rtl/fpap_ram.sv -----
module fpap_ram
    import fpap_pkg::*;
#(
    parameter int WIDTH = SAMPLE_W,
    parameter int DEPTH = CHANNELS_DEF * STAGES_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/four_pole_allpass_phaser_core.sv -----
// Items run one at a time: a new input is taken only while the sequencer is idle. The single
// shared multiplier serves the coefficient, feedback, each stage and the mix in turn.
// A finished result waits in the output register while the next item is already taken in.
// Reset (synchronous, active low) zeroes the gain registers and marks every channel's delay
// row as empty, so stage delays read as zero until a channel has been processed once.
module four_pole_allpass_phaser_core
    import fpap_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF,
    parameter int STAGES   = STAGES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration write channel.
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [GAIN_W-1:0]           i_cfg_data,
    // Input channel.
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [CHAN_FIELD_W-1:0]     i_channel,
    input  logic signed [SAMPLE_W-1:0]  i_sample_in,
    input  logic signed [SAMPLE_W-1:0]  i_cv_in,
    // Output channel.
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [CHAN_FIELD_W-1:0]     o_channel_out,
    output logic signed [SAMPLE_W-1:0]  o_wet_out,
    output logic signed [SAMPLE_W-1:0]  o_mix_out
);

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ST_W  = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int DEPTH = CHANNELS * STAGES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NCODE = 2 ** CHAN_FIELD_W;

    // Sequencer.
    t_state r_state;
    t_state n_state;
    logic   w_in_fire;
    logic   w_we;
    logic   w_out_load;
    logic   w_last_stage;

    // Configuration.
    logic [GAIN_W-1:0] r_fb_gain;
    logic [GAIN_W-1:0] r_mix_amount;
    logic [GAIN_W-1:0] r_cv_depth;

    // Item registers.
    logic [CHAN_FIELD_W-1:0]    r_chan_field;
    logic [CH_W-1:0]            r_chan;
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [SAMPLE_W-1:0] r_cv;
    logic signed [SAMPLE_W-1:0] r_fbd;
    logic signed [SAMPLE_W-1:0] r_id;
    logic signed [SAMPLE_W-1:0] r_sig;
    logic [18:0]                r_u;
    logic                       r_clo;
    logic                       r_chi;
    logic [GAIN_W-1:0]          r_coef;
    logic [ST_W-1:0]            r_stage;
    logic signed [PROD_W-1:0]   r_prod;
    logic [CHANNELS-1:0]        r_row_valid;

    // Output register.
    logic                       r_out_valid;
    logic [CHAN_FIELD_W-1:0]    r_chan_out;
    logic signed [SAMPLE_W-1:0] r_wet;
    logic signed [SAMPLE_W-1:0] r_mix;

    // Channel wrap table, worked out at elaboration.
    logic [CH_W-1:0] w_wrap [NCODE];

    for (genvar g = 0; g < NCODE; g++) begin : g_wrap
        localparam int WRAPPED = g % CHANNELS;
        assign w_wrap[g] = CH_W'(WRAPPED);
    end

    // Memory addressing.
    logic [AW-1:0]              w_in_base;
    logic [AW-1:0]              w_base;
    logic [AW-1:0]              w_waddr;
    logic [AW-1:0]              w_raddr;
    logic [SAMPLE_W-1:0]        w_id_rdata;
    logic [SAMPLE_W-1:0]        w_od_rdata;
    logic signed [SAMPLE_W-1:0] w_id;
    logic signed [SAMPLE_W-1:0] w_od;
    logic signed [SAMPLE_W-1:0] w_ys;

    assign w_in_base = AW'(w_wrap[i_channel]) * AW'(STAGES);
    assign w_base    = AW'(r_chan) * AW'(STAGES);
    assign w_waddr   = w_base + AW'(r_stage);
    assign w_last_stage = (r_stage == ST_W'(STAGES - 1));

    // Read address follows the sequencer: last stage for feedback, then stage by stage.
    always_comb begin
        case (r_state)
            S_IDLE:  w_raddr = w_in_base + AW'(STAGES - 1);
            S_COEF:  w_raddr = w_base;
            S_ACC:   w_raddr = w_last_stage ? w_base : w_waddr + AW'(1);
            default: w_raddr = w_waddr;
        endcase
    end

    fpap_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_in_delay (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_sig),
        .i_raddr (w_raddr),
        .o_rdata (w_id_rdata)
    );

    fpap_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_out_delay (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_ys),
        .i_raddr (w_raddr),
        .o_rdata (w_od_rdata)
    );

    // A row never written since reset reads as zero.
    assign w_id = r_row_valid[r_chan] ? $signed(w_id_rdata) : '0;
    assign w_od = r_row_valid[r_chan] ? $signed(w_od_rdata) : '0;

    // Shared multiplier operand selection.
    logic signed [MA_W-1:0] w_ma;
    logic signed [MB_W-1:0] w_mb;
    logic signed [MA_W-1:0] w_diff;

    assign w_diff = MA_W'(r_sig) - MA_W'(w_od);

    always_comb begin
        case (r_state)
            S_CV: begin
                w_ma = MA_W'(r_cv);
                w_mb = $signed({2'b00, r_cv_depth});
            end
            S_FB: begin
                w_ma = MA_W'(r_fbd);
                w_mb = $signed({2'b00, r_fb_gain});
            end
            S_REC: begin
                w_ma = $signed({6'b000000, r_u});
                w_mb = RECIP_5;
            end
            S_MUL: begin
                w_ma = w_diff;
                w_mb = $signed({2'b00, r_coef});
            end
            S_MIXM: begin
                w_ma = MA_W'(r_x);
                w_mb = $signed({2'b00, r_mix_amount});
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // Coefficient: bias and scale the cv product, then clamp flags and offset.
    logic signed [PROD_W-1:0] w_nb;
    logic signed [23:0]       w_m;
    logic signed [23:0]       w_u_full;

    assign w_nb     = r_prod + CV_BIAS;
    assign w_m      = w_nb[43:20];
    assign w_u_full = w_m + U_OFS;

    // Divide by five: reciprocal estimate plus one correction step.
    logic [GAIN_W-1:0] w_q0;
    logic [19:0]       w_q5;
    logic [19:0]       w_rem;
    logic [GAIN_W-1:0] w_q;
    logic [GAIN_W-1:0] w_coef;

    assign w_q0   = r_prod[36:20];
    assign w_q5   = (20'(w_q0) << 2) + 20'(w_q0);
    assign w_rem  = 20'(r_u) - w_q5;
    assign w_q    = (w_rem >= 20'd5) ? w_q0 + 17'd1 : w_q0;
    assign w_coef = r_clo ? '0 : (r_chi ? Q16_ONE : w_q);

    // Feedback subtraction, stage result and mix.
    logic signed [29:0] w_s0;
    logic signed [29:0] w_y;
    logic signed [29:0] w_mixv;

    assign w_s0   = 30'(r_x) - 30'(round_q16(r_prod));
    assign w_y    = 30'(round_q16(r_prod)) + 30'(r_id);
    assign w_ys   = sat24(w_y);
    assign w_mixv = 30'(r_sig) + 30'(round_q16(r_prod));

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and strobes.
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        w_we       = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_CV;
                end
            end
            S_CV:   n_state = S_FB;
            S_FB:   n_state = S_REC;
            S_REC:  n_state = S_COEF;
            S_COEF: n_state = S_MUL;
            S_MUL:  n_state = S_ACC;
            S_ACC: begin
                w_we    = 1'b1;
                n_state = w_last_stage ? S_MIXM : S_MUL;
            end
            S_MIXM: n_state = S_DONE;
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign w_in_fire = i_in_valid && o_in_ready;

    // Configuration registers; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb_gain    <= '0;
            r_mix_amount <= '0;
            r_cv_depth   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FEEDBACK: r_fb_gain    <= clamp_gain(i_cfg_data);
                CFG_MIX:      r_mix_amount <= clamp_gain(i_cfg_data);
                CFG_DEPTH:    r_cv_depth   <= clamp_gain(i_cfg_data);
                default:      ;
            endcase
        end
    end

    // Control state: stage counter, row valid bits, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage     <= '0;
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_fire) begin
                r_stage <= '0;
            end else if (r_state == S_ACC && !w_last_stage) begin
                r_stage <= r_stage + ST_W'(1);
            end
            if (r_state == S_ACC && w_last_stage) begin
                r_row_valid[r_chan] <= 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        // The mix product is held while a finished item waits for the output register.
        if (r_state != S_DONE) begin
            r_prod <= PROD_W'(w_ma * w_mb);
        end
        if (w_in_fire) begin
            r_chan_field <= i_channel;
            r_chan       <= w_wrap[i_channel];
            r_x          <= i_sample_in;
            r_cv         <= i_cv_in;
        end
        case (r_state)
            S_CV: r_fbd <= w_od;
            S_FB: begin
                r_clo <= (w_m < M_LO);
                r_chi <= (w_m > M_HI);
                r_u   <= w_u_full[18:0];
            end
            S_REC:  r_sig  <= sat24(w_s0);
            S_COEF: r_coef <= w_coef;
            S_MUL:  r_id   <= w_id;
            S_ACC:  r_sig  <= w_ys;
            default: ;
        endcase
        if (w_out_load) begin
            r_chan_out <= r_chan_field;
            r_wet      <= r_sig;
            r_mix      <= sat24(w_mixv);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_channel_out = r_chan_out;
    assign o_wet_out     = r_wet;
    assign o_mix_out     = r_mix;

    // The coefficient never exceeds unity when a stage uses it.
    a_coef_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_coef <= Q16_ONE))
        else $error("allpass coefficient above unity");

    // The reciprocal estimate is at most one below the true quotient.
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COEF) |-> (w_rem < 20'd10))
        else $error("divide-by-five correction out of range");

    // The stage counter stays inside the stage count.
    a_stage_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_stage} < (ST_W + 1)'(STAGES)))
        else $error("stage counter out of range");

    // A result appears only when the sequencer finishes an item.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result loaded outside the final state");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

import fpap_pkg::*;

// One expected result of the phaser.
typedef struct {
    logic [CHAN_FIELD_W-1:0]    channel;
    logic signed [SAMPLE_W-1:0] wet;
    logic signed [SAMPLE_W-1:0] mix;
} t_phaser_result;

// Tracks the per-channel allpass state, predicts each result and checks the block against it.
class t_phaser_scoreboard;
    logic [GAIN_W-1:0]          feedback_gain;
    logic [GAIN_W-1:0]          mix_amount;
    logic [GAIN_W-1:0]          cv_depth;
    logic signed [SAMPLE_W-1:0] stage_in_hist [CHANNELS_DEF*STAGES_DEF];
    logic signed [SAMPLE_W-1:0] stage_out_hist [CHANNELS_DEF*STAGES_DEF];
    t_phaser_result             awaited [$];
    int                         failures;

    function new();
        feedback_gain = '0;
        mix_amount    = '0;
        cv_depth      = '0;
        failures      = 0;
        foreach (stage_in_hist[i]) begin
            stage_in_hist[i]  = '0;
            stage_out_hist[i] = '0;
        end
    endfunction

    function int pending();
        return awaited.size();
    endfunction

    // Division that rounds toward minus infinity; the divisor is always positive here.
    function longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    // Drop 16 fraction bits, rounding to nearest with halves going up.
    function longint nearest_q16(longint v);
        return (v + 32768) >>> 16;
    endfunction

    function longint clip24(longint v);
        if (v > 8388607) begin
            return 8388607;
        end else if (v < -8388608) begin
            return -8388608;
        end
        return v;
    endfunction

    // Gains above unity are held at unity; writes past the register list are dropped.
    function void set_register(logic [CFG_IDX_W-1:0] index, logic [GAIN_W-1:0] data);
        logic [GAIN_W-1:0] gain;
        gain = (data > Q16_ONE) ? Q16_ONE : data;
        case (index)
            CFG_FEEDBACK: feedback_gain = gain;
            CFG_MIX:      mix_amount = gain;
            CFG_DEPTH:    cv_depth = gain;
            default:      ;
        endcase
    endfunction

    // Run one accepted input transaction through the four stages and queue its result.
    function void note_input(logic [CHAN_FIELD_W-1:0] ch, logic signed [SAMPLE_W-1:0] sample,
                             logic signed [SAMPLE_W-1:0] cv);
        longint         x;
        longint         ctl;
        longint         coef;
        longint         sig;
        longint         ys;
        longint         fb;
        longint         dry_gain;
        longint         depth;
        int             base;
        int             k;
        t_phaser_result r;
        x        = longint'(sample);
        ctl      = longint'(cv);
        fb       = longint'(feedback_gain);
        dry_gain = longint'(mix_amount);
        depth    = longint'(cv_depth);
        base     = (int'(ch) % CHANNELS_DEF) * STAGES_DEF;

        // Coefficient: cv/10 V scaled by depth, centered on one half, held within [0, 1].
        coef = floor_div(ctl * depth + 5 * 524288, 10 * 524288) + 32768;
        if (coef < 0) begin
            coef = 0;
        end
        if (coef > 65536) begin
            coef = 65536;
        end

        // Subtract feedback from the last stage of this channel.
        sig = clip24(x - nearest_q16(fb * longint'(stage_out_hist[base + STAGES_DEF - 1])));

        for (int s = 0; s < STAGES_DEF; s++) begin
            k  = base + s;
            ys = clip24(nearest_q16((sig - longint'(stage_out_hist[k])) * coef) +
                        longint'(stage_in_hist[k]));
            stage_in_hist[k]  = SAMPLE_W'(sig);
            stage_out_hist[k] = SAMPLE_W'(ys);
            sig = ys;
        end

        r.channel = ch;
        r.wet     = SAMPLE_W'(sig);
        r.mix     = SAMPLE_W'(clip24(sig + nearest_q16(x * dry_gain)));
        awaited.push_back(r);
    endfunction

    // Compare one result transaction with the oldest prediction.
    function void check_result(logic [CHAN_FIELD_W-1:0] ch, logic signed [SAMPLE_W-1:0] wet,
                               logic signed [SAMPLE_W-1:0] mix);
        t_phaser_result r;
        if (awaited.size() == 0) begin
            $display("%0t: result with nothing expected: channel %0d wet %0d mix %0d",
                     $time, ch, wet, mix);
            failures++;
            return;
        end
        r = awaited.pop_front();
        if (ch !== r.channel) begin
            $display("%0t: channel_out expected %0d, got %0d", $time, r.channel, ch);
            failures++;
        end
        if (wet !== r.wet) begin
            $display("%0t: wet_out expected %0d, got %0d", $time, r.wet, wet);
            failures++;
        end
        if (mix !== r.mix) begin
            $display("%0t: mix_out expected %0d, got %0d", $time, r.mix, mix);
            failures++;
        end
    endfunction
endclass

module testbench;
    import fpap_pkg::*;

    // Index past the end of the register list; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic signed [SAMPLE_W-1:0] LEVEL_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] LEVEL_MIN = 24'sh800000;
    localparam int HOLD_CYCLES  = 200;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 2 * (6 + 2 * STAGES_DEF);
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 123;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [GAIN_W-1:0]          i_cfg_data = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic [CHAN_FIELD_W-1:0]    i_channel = '0;
    logic signed [SAMPLE_W-1:0] i_sample_in = '0;
    logic signed [SAMPLE_W-1:0] i_cv_in = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [CHAN_FIELD_W-1:0]    o_channel_out;
    logic signed [SAMPLE_W-1:0] o_wet_out;
    logic signed [SAMPLE_W-1:0] o_mix_out;

    t_phaser_scoreboard sb = new();
    int in_gap_max  = 14;
    int out_gap_max = 14;
    bit hold_request = 1'b0;
    int quiet_cycles = 0;

    four_pole_allpass_phaser_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_channel     (i_channel),
        .i_sample_in   (i_sample_in),
        .i_cv_in       (i_cv_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_channel_out (o_channel_out),
        .o_wet_out     (o_wet_out),
        .o_mix_out     (o_mix_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Observe every transaction on all three channels at the clock edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                sb.set_register(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && o_in_ready) begin
                sb.note_input(i_channel, i_sample_in, i_cv_in);
            end
            if (o_out_valid && i_out_ready) begin
                sb.check_result(o_channel_out, o_wet_out, o_mix_out);
            end
            if ((i_cfg_valid && o_cfg_ready) || (i_in_valid && o_in_ready) ||
                (o_out_valid && i_out_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Give up once the block has gone quiet for far longer than any correct run allows.
    initial begin
        do @(posedge i_clk); while (quiet_cycles < STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: random stalls per transaction, plus one long hold-off on request.
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                gap = HOLD_CYCLES;
            end else begin
                gap = (out_gap_max == 0) ? 0 : $urandom_range(0, out_gap_max);
            end
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Offer one input transaction after a random gap; valid stays up between back-to-back items.
    task automatic send_item(input logic [CHAN_FIELD_W-1:0] ch,
                             input logic signed [SAMPLE_W-1:0] sample,
                             input logic signed [SAMPLE_W-1:0] cv);
        int gap;
        gap = (in_gap_max == 0) ? 0 : $urandom_range(0, in_gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_channel   <= ch;
        i_sample_in <= sample;
        i_cv_in     <= cv;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Stop offering and wait until every predicted result has come back.
    task automatic finish_items();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Register write; the caller lowers valid after the last write of a group.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [GAIN_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Gains: zero, unity, above unity (clamped) or anywhere in between.
    function automatic logic [GAIN_W-1:0] draw_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return Q16_ONE;
            2:       return GAIN_W'($urandom_range(65537, 131071));
            default: return GAIN_W'($urandom_range(0, 65536));
        endcase
    endfunction

    // Levels: full scale, quiet, around the points where the coefficient clamps, or anything.
    function automatic logic signed [SAMPLE_W-1:0] draw_level();
        case ($urandom_range(0, 7))
            0:       return LEVEL_MAX;
            1:       return LEVEL_MIN;
            2:       return SAMPLE_W'(int'($urandom_range(0, 4095)) - 2048);
            3:       return SAMPLE_W'(2621440 + int'($urandom_range(0, 255)) - 128);
            4:       return SAMPLE_W'(-2621440 + int'($urandom_range(0, 255)) - 128);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    initial begin
        bit                      narrow;
        logic [CHAN_FIELD_W-1:0] home;
        logic [CHAN_FIELD_W-1:0] ch;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Gains at their reset value: coefficient at one half, no feedback, no dry path.
        send_item(4'd0, LEVEL_MAX, '0);
        send_item(4'd0, LEVEL_MIN, LEVEL_MAX);
        send_item(4'd15, '0, LEVEL_MIN);
        finish_items();

        // Feedback written above unity, full mix and depth, and a write past the register list.
        write_reg(CFG_FEEDBACK, 17'h1FFFF);
        write_reg(CFG_MIX, Q16_ONE);
        write_reg(CFG_DEPTH, Q16_ONE);
        write_reg(CFG_SPARE, 17'h00F0F);
        i_cfg_valid <= 1'b0;

        // Coefficient pinned at one and at zero, then full-scale drive into saturated feedback.
        send_item(4'd15, LEVEL_MAX, LEVEL_MAX);
        send_item(4'd15, LEVEL_MIN, LEVEL_MIN);
        repeat (4) send_item(4'd3, LEVEL_MAX, '0);
        repeat (2) begin
            send_item(4'd3, LEVEL_MIN, 24'sd2621440);
            send_item(4'd3, LEVEL_MAX, -24'sd2621440);
        end
        send_item(4'd7, '0, '0);
        send_item(4'd8, 24'sd1, -24'sd1);
        finish_items();

        // Random phases, each with its own gains, channel spread and idling style.
        for (int phase = 0; phase < PHASES; phase++) begin
            in_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : 14;
            out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
            narrow      = ($urandom_range(0, 2) == 0);
            home        = CHAN_FIELD_W'($urandom_range(0, 14));
            if (phase == 0) begin
                write_reg(CFG_FEEDBACK, '0);
                write_reg(CFG_MIX, '0);
                write_reg(CFG_DEPTH, '0);
            end else begin
                if ($urandom_range(0, 3) != 0) write_reg(CFG_FEEDBACK, draw_gain());
                if ($urandom_range(0, 3) != 0) write_reg(CFG_MIX, draw_gain());
                if ($urandom_range(0, 3) != 0) write_reg(CFG_DEPTH, draw_gain());
                if ($urandom_range(0, 4) == 0) write_reg(CFG_SPARE, GAIN_W'($urandom));
            end
            i_cfg_valid <= 1'b0;
            if (phase == 2 || phase == 7) begin
                hold_request = 1'b1;
            end
            repeat (PHASE_ITEMS) begin
                ch = narrow ? CHAN_FIELD_W'(home + $urandom_range(0, 1))
                            : CHAN_FIELD_W'($urandom_range(0, 15));
                send_item(ch, draw_level(), draw_level());
            end
            finish_items();
        end

        // Let anything stray come out before judging.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
        end
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
